>>> hw/rtl/softened_point_mass_force_assert.svh
// Assertion macros for the softened point-mass force block.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef SOFTENED_POINT_MASS_FORCE_ASSERT_SVH
`define SOFTENED_POINT_MASS_FORCE_ASSERT_SVH

`define SPMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define SPMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/spmf_pkg.sv
// Shared widths, saturation limits and sideband types of the point-mass force block.
// No dependencies.
package spmf_pkg;

    localparam int DATA_W     = 32;
    localparam int DIFF_W     = 33;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 64;
    localparam int SUM_W      = 66;
    localparam int ROOT_W     = 33;
    localparam int GUARD_BITS = 8;
    localparam int AXES       = 3;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic [DATA_W-1:0]  mass;
        mag_t [AXES-1:0]    mag;
        logic [AXES-1:0]    neg;
        logic               frozen;
        logic               last;
    } item_side_t;

endpackage

>>> hw/rtl/spmf_front.sv
// Front stages: offset, magnitude, squares and softened squared distance.
// Depends on spmf_pkg.
module spmf_front import spmf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [DATA_W-1:0]   in_pos [AXES],
    input  logic [DATA_W-1:0]   in_sat [AXES],
    input  logic [DATA_W-1:0]   in_mass,
    input  logic                in_frozen,
    input  logic                in_last,
    input  logic [DATA_W-1:0]   in_core,
    output logic                out_valid,
    output logic [SUM_W-1:0]    out_sum,
    output item_side_t          out_side
);

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [DIFF_W-1:0] diff_reg [AXES];
    logic [DATA_W-1:0] core1_reg, core2_reg;
    logic [DATA_W-1:0] mass1_reg;
    logic              frozen1_reg, last1_reg;
    item_side_t        side2_reg, side3_reg, side4_reg, side5_reg;
    item_side_t        side2_next;
    logic [SQ_W-1:0]   sq3_reg [AXES];
    logic [SQ_W-1:0]   csq3_reg;
    logic [SUM_W-1:0]  suma4_reg, sumb4_reg, sum5_reg;
    logic [DIFF_W-1:0] diff_neg [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_comb begin
        side2_next.mass   = mass1_reg;
        side2_next.frozen = frozen1_reg;
        side2_next.last   = last1_reg;
        for (int k = 0; k < AXES; k++) begin
            diff_neg[k]        = -diff_reg[k];
            side2_next.neg[k]  = diff_reg[k][DIFF_W-1];
            side2_next.mag[k]  = diff_reg[k][DIFF_W-1] ? MAG_W'(diff_neg[k])
                                                       : MAG_W'(diff_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < AXES; k++) begin
                diff_reg[k] <= {in_pos[k][DATA_W-1], in_pos[k]}
                             - {in_sat[k][DATA_W-1], in_sat[k]};
                sq3_reg[k]  <= SQ_W'(side2_reg.mag[k]) * SQ_W'(side2_reg.mag[k]);
            end
            core1_reg   <= in_core;
            mass1_reg   <= in_mass;
            frozen1_reg <= in_frozen;
            last1_reg   <= in_last;

            side2_reg   <= side2_next;
            core2_reg   <= core1_reg;

            side3_reg   <= side2_reg;
            csq3_reg    <= SQ_W'(core2_reg) * SQ_W'(core2_reg);

            side4_reg   <= side3_reg;
            suma4_reg   <= SUM_W'(csq3_reg) + SUM_W'(sq3_reg[0]);
            sumb4_reg   <= SUM_W'(sq3_reg[1]) + SUM_W'(sq3_reg[2]);

            side5_reg   <= side4_reg;
            sum5_reg    <= suma4_reg + sumb4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_sum   = sum5_reg;
    assign out_side  = side5_reg;

endmodule

>>> hw/rtl/spmf_isqrt.sv
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on spmf_pkg.
module spmf_isqrt import spmf_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SUM_W-1:0]    in_sum,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    logic              valid_reg [ROOT_W];
    logic [SUM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        localparam int B = ROOT_W - 1 - i;
        logic              valid_cur;
        logic [SUM_W-1:0]  rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [SUM_W:0]    trial;
        logic [SUM_W:0]    rem_diff;
        logic              take;

        if (i == 0) begin : g_head
            assign valid_cur = in_valid;
            assign rem_cur   = in_sum;
            assign root_cur  = '0;
            assign side_cur  = in_side;
        end else begin : g_body
            assign valid_cur = valid_reg[i-1];
            assign rem_cur   = rem_reg[i-1];
            assign root_cur  = root_reg[i-1];
            assign side_cur  = side_reg[i-1];
        end

        assign trial    = ((SUM_W+1)'(root_cur) << (B + 1)) | ((SUM_W+1)'(1) << (2 * B));
        assign take     = trial <= {1'b0, rem_cur};
        assign rem_diff = {1'b0, rem_cur} - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? SUM_W'(rem_diff) : rem_cur;
                root_reg[i] <= take ? (root_cur | (ROOT_W'(1) << B)) : root_cur;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

>>> hw/rtl/spmf_div.sv
// Pipelined restoring divider, several lanes over one shared divisor, one quotient
// bit per stage; flags quotients at or above 2^QW. No package dependency.
module spmf_div #(
    parameter int NW     = 57,
    parameter int QW     = 56,
    parameter int DW     = 33,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     in_num [LANES],
    input  logic [DW-1:0]     in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QW-1:0]     out_quo [LANES],
    output logic [LANES-1:0]  out_ovf,
    output logic [DW-1:0]     out_den,
    output logic [SIDE_W-1:0] out_side
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic              valid_reg [QW+1];
    logic [DW-1:0]     rem_reg   [QW+1][LANES];
    logic [QW-1:0]     nq_reg    [QW+1][LANES];
    logic [LANES-1:0]  ovf_reg   [QW+1];
    logic [DW-1:0]     den_reg   [QW+1];
    logic [SIDE_W-1:0] side_reg  [QW+1];

    logic [HW-1:0]     high      [LANES];
    logic [DW-1:0]     rem_next  [LANES];
    logic [LANES-1:0]  ovf_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            high[l]     = in_num[l][NW-1:QW];
            ovf_next[l] = CW'(high[l]) >= CW'(in_den);
            rem_next[l] = DW'(high[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= rem_next[l];
                nq_reg[0][l]  <= in_num[l][QW-1:0];
            end
            ovf_reg[0]  <= ovf_next;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_step
        logic [DW:0]      rem2    [LANES];
        logic [LANES-1:0] ge;
        logic [DW-1:0]    rem_new [LANES];
        logic [QW-1:0]    nq_new  [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                rem2[l]    = {rem_reg[j-1][l], nq_reg[j-1][l][QW-1]};
                ge[l]      = rem2[l] >= {1'b0, den_reg[j-1]};
                rem_new[l] = ge[l] ? DW'(rem2[l] - {1'b0, den_reg[j-1]}) : DW'(rem2[l]);
                nq_new[l]  = {nq_reg[j-1][l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[j][l] <= rem_new[l];
                    nq_reg[j][l]  <= nq_new[l];
                end
                ovf_reg[j]  <= ovf_reg[j-1];
                den_reg[j]  <= den_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_quo[l] = nq_reg[QW][l];
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_ovf   = ovf_reg[QW];
    assign out_den   = den_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

>>> hw/rtl/softened_point_mass_force.sv
// Channel  | Direction | Carries
// s_       | in        | particle and satellite position, mass, frozen, last flag
// m_       | out       | acceleration and potential increments, last flag
// cfg_     | in        | softening length
// One particle enters per cycle unless a held result on m_ stalls the pipeline; the path
// runs through the square root (33 stages) and two long-division pipelines (one bit a stage).
// Reset clears all valid bits and loads the softening length with 0.5.
// A held result on m_ stalls every stage at once; nothing moves, nothing is lost.
// Depends on spmf_pkg, spmf_front, spmf_isqrt, spmf_div and the assertion header.
`include "softened_point_mass_force_assert.svh"

module softened_point_mass_force import spmf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_pos_x,
    input  logic signed [DATA_W-1:0] s_pos_y,
    input  logic signed [DATA_W-1:0] s_pos_z,
    input  logic signed [DATA_W-1:0] s_sat_x,
    input  logic signed [DATA_W-1:0] s_sat_y,
    input  logic signed [DATA_W-1:0] s_sat_z,
    input  logic [DATA_W-1:0]        s_sat_mass,
    input  logic                     s_frozen,
    input  logic                     s_last_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_dacc_x,
    output logic signed [DATA_W-1:0] m_dacc_y,
    output logic signed [DATA_W-1:0] m_dacc_z,
    output logic signed [DATA_W-1:0] m_dpot,
    output logic                     m_last_out,
    input  logic                     cfg_wr_en,
    input  logic [DATA_W-1:0]        cfg_wr_data
);

    localparam int D1_NW   = DATA_W + FRAC_BITS + GUARD_BITS + 1;
    localparam int D1_QW   = D1_NW - 1;
    localparam int U_W     = FRAC_BITS + 1;
    localparam int PROD_W  = D1_QW + U_W;
    localparam int D2_DW   = ROOT_W + GUARD_BITS;
    localparam int D2_QW   = DATA_W - 1;
    localparam int D1_LANES = 2 + AXES;

    typedef struct packed {
        logic [AXES-1:0] neg;
        logic            frozen;
        logic            last;
        logic            mass_zero;
    } tail_t;

    typedef struct packed {
        tail_t             tail;
        logic              p_sat;
        logic [DATA_W-2:0] p_mag;
    } mid_t;

    function automatic logic [DATA_W-1:0] sat_axis(
        input logic [DATA_W-2:0] q,
        input logic              big,
        input logic              neg
    );
        logic [DATA_W-1:0] res;
        if (neg) begin
            res = big ? SAT_MAX : {1'b0, q};
        end else begin
            res = big ? SAT_MIN : -{1'b0, q};
        end
        return res;
    endfunction

    logic              pipe_en;
    logic [DATA_W-1:0] core_size_reg;

    logic [DATA_W-1:0] pos_arr [AXES];
    logic [DATA_W-1:0] sat_arr [AXES];

    logic              fr_valid;
    logic [SUM_W-1:0]  fr_sum;
    item_side_t        fr_side;

    logic              isq_valid;
    logic [ROOT_W-1:0] isq_root;
    item_side_t        isq_side;
    tail_t             isq_tail;

    logic [D1_NW-1:0]  d1_num [D1_LANES];
    logic              d1_valid;
    logic [D1_QW-1:0]  d1_quo [D1_LANES];
    logic [D1_LANES-1:0] d1_ovf;
    logic [ROOT_W-1:0] d1_den;
    tail_t             d1_tail;

    logic              mul_valid_reg;
    logic [PROD_W-1:0] prod_reg [AXES];
    logic [ROOT_W-1:0] mul_den_reg;
    mid_t              mul_mid_reg;
    mid_t              mul_mid_next;
    logic [D2_DW-1:0]  d2_den_in;

    logic              d2_valid;
    logic [D2_QW-1:0]  d2_quo [AXES];
    logic [AXES-1:0]   d2_ovf;
    logic [D2_DW-1:0]  d2_den;
    mid_t              d2_mid;

    logic              m_valid_reg;
    logic [DATA_W-1:0] dacc_reg [AXES];
    logic [DATA_W-1:0] dpot_reg;
    logic              last_reg;
    logic [DATA_W-1:0] dacc_next [AXES];
    logic [DATA_W-1:0] dpot_next;
    logic              root_zero;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_size_reg <= DATA_W'(32768);
        end else if (cfg_wr_en) begin
            core_size_reg <= cfg_wr_data;
        end
    end

    assign pos_arr[0] = s_pos_x;
    assign pos_arr[1] = s_pos_y;
    assign pos_arr[2] = s_pos_z;
    assign sat_arr[0] = s_sat_x;
    assign sat_arr[1] = s_sat_y;
    assign sat_arr[2] = s_sat_z;

    spmf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .in_pos    (pos_arr),
        .in_sat    (sat_arr),
        .in_mass   (s_sat_mass),
        .in_frozen (s_frozen),
        .in_last   (s_last_in),
        .in_core   (core_size_reg),
        .out_valid (fr_valid),
        .out_sum   (fr_sum),
        .out_side  (fr_side)
    );

    spmf_isqrt #(
        .SIDE_W ($bits(item_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (fr_valid),
        .in_sum    (fr_sum),
        .in_side   (fr_side),
        .out_valid (isq_valid),
        .out_root  (isq_root),
        .out_side  (isq_side)
    );

    always_comb begin
        d1_num[0] = D1_NW'(isq_side.mass) << FRAC_BITS;
        d1_num[1] = D1_NW'(isq_side.mass) << (FRAC_BITS + GUARD_BITS);
        for (int k = 0; k < AXES; k++) begin
            d1_num[2+k] = D1_NW'(isq_side.mag[k]) << FRAC_BITS;
        end
        isq_tail.neg       = isq_side.neg;
        isq_tail.frozen    = isq_side.frozen;
        isq_tail.last      = isq_side.last;
        isq_tail.mass_zero = isq_side.mass == '0;
    end

    spmf_div #(
        .NW     (D1_NW),
        .QW     (D1_QW),
        .DW     (ROOT_W),
        .LANES  (D1_LANES),
        .SIDE_W ($bits(tail_t))
    ) u_div_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (isq_valid),
        .in_num    (d1_num),
        .in_den    (isq_root),
        .in_side   (isq_tail),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_ovf   (d1_ovf),
        .out_den   (d1_den),
        .out_side  (d1_tail)
    );

    always_comb begin
        mul_mid_next.tail  = d1_tail;
        mul_mid_next.p_sat = d1_ovf[0] || (|d1_quo[0][D1_QW-1:DATA_W-1]);
        mul_mid_next.p_mag = d1_quo[0][DATA_W-2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            mul_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < AXES; k++) begin
                prod_reg[k] <= PROD_W'(d1_quo[1]) * PROD_W'(d1_quo[2+k][U_W-1:0]);
            end
            mul_den_reg <= d1_den;
            mul_mid_reg <= mul_mid_next;
        end
    end

    assign d2_den_in = D2_DW'(mul_den_reg) << GUARD_BITS;

    spmf_div #(
        .NW     (PROD_W),
        .QW     (D2_QW),
        .DW     (D2_DW),
        .LANES  (AXES),
        .SIDE_W ($bits(mid_t))
    ) u_div_force (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (mul_valid_reg),
        .in_num    (prod_reg),
        .in_den    (d2_den_in),
        .in_side   (mul_mid_reg),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_ovf   (d2_ovf),
        .out_den   (d2_den),
        .out_side  (d2_mid)
    );

    assign root_zero = d2_den == '0;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            dacc_next[k] = (d2_mid.tail.frozen || root_zero) ? '0
                         : sat_axis(d2_quo[k], d2_ovf[k], d2_mid.tail.neg[k]);
        end
        if (d2_mid.tail.frozen || d2_mid.tail.mass_zero) begin
            dpot_next = '0;
        end else if (d2_mid.p_sat) begin
            dpot_next = SAT_MIN;
        end else begin
            dpot_next = -{1'b0, d2_mid.p_mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < AXES; k++) begin
                dacc_reg[k] <= dacc_next[k];
            end
            dpot_reg <= dpot_next;
            last_reg <= d2_mid.tail.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_dacc_x   = dacc_reg[0];
    assign m_dacc_y   = dacc_reg[1];
    assign m_dacc_z   = dacc_reg[2];
    assign m_dpot     = dpot_reg;
    assign m_last_out = last_reg;

    `SPMF_ASSERT_NEXT(a_frozen_zero, pipe_en && d2_valid && d2_mid.tail.frozen, m_dpot == '0 && m_dacc_x == '0 && m_dacc_y == '0 && m_dacc_z == '0, "frozen particle gave a nonzero increment")
    `SPMF_ASSERT_NEXT(a_root_zero, pipe_en && d2_valid && d2_den == '0, m_dacc_x == '0 && m_dacc_y == '0 && m_dacc_z == '0, "zero root gave a nonzero acceleration")
    `SPMF_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(d2_valid) && $stable(mul_valid_reg) && m_valid, "pipeline moved during a stall")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for softened_point_mass_force: random and directed particles
// go in through a queue-fed driver, and a clocked monitor compares every result with a
// local wide-integer predictor. Depends on spmf_pkg and the block's RTL.
module testbench import spmf_pkg::*;;

    localparam int  FRAC       = 16;
    localparam int  LATENCY    = 113 + FRAC;
    localparam int  LIMIT      = 600000;

    typedef struct {
        logic signed [DATA_W-1:0] px, py, pz, sx, sy, sz;
        logic [DATA_W-1:0]        mass;
        logic                     frozen, last;
    } particle_t;

    typedef struct {
        logic signed [DATA_W-1:0] ax, ay, az, pot;
        logic                     last;
    } force_t;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [DATA_W-1:0] s_pos_x, s_pos_y, s_pos_z, s_sat_x, s_sat_y, s_sat_z;
    logic [DATA_W-1:0] s_sat_mass;
    logic s_frozen, s_last_in;
    logic signed [DATA_W-1:0] m_dacc_x, m_dacc_y, m_dacc_z, m_dpot;
    logic m_last_out;
    logic cfg_wr_en;
    logic [DATA_W-1:0] cfg_wr_data;

    particle_t pending_particles[$];
    force_t    expected_forces[$];
    particle_t cur_particle;
    logic [31:0] core_size_model;
    int unsigned cycles, errors, s_gap, m_stall;
    bit s_taken, no_idle;

    softened_point_mass_force #(.FRAC_BITS(FRAC)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_sat_x(s_sat_x), .s_sat_y(s_sat_y), .s_sat_z(s_sat_z),
        .s_sat_mass(s_sat_mass), .s_frozen(s_frozen), .s_last_in(s_last_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_dacc_x(m_dacc_x), .m_dacc_y(m_dacc_y), .m_dacc_z(m_dacc_z),
        .m_dpot(m_dpot), .m_last_out(m_last_out),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [127:0] floor_sqrt(logic [127:0] v);
        logic [127:0] r, c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] saturate(logic [127:0] mag, bit neg);
        if (neg) begin
            if (mag >= 128'h8000_0000) return SAT_MIN;
            return 32'(-mag);
        end
        if (mag > 128'h7FFF_FFFF) return SAT_MAX;
        return mag[31:0];
    endfunction

    function automatic force_t plummer_force(particle_t p, logic [31:0] core);
        force_t f;
        logic signed [63:0] d [3];
        logic [127:0] mag [3];
        logic [127:0] s, r, t, u, q, m;
        f.last = p.last;
        f.ax = '0; f.ay = '0; f.az = '0; f.pot = '0;
        if (p.frozen) return f;
        d[0] = 64'(p.px) - 64'(p.sx);
        d[1] = 64'(p.py) - 64'(p.sy);
        d[2] = 64'(p.pz) - 64'(p.sz);
        m = 128'(p.mass);
        s = 128'(core) * 128'(core);
        for (int k = 0; k < 3; k++) begin
            mag[k] = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
            s += mag[k] * mag[k];
        end
        r = floor_sqrt(s);
        if (r == 0) begin
            f.pot = (p.mass != 0) ? SAT_MIN : '0;
            return f;
        end
        f.pot = saturate((m << FRAC) / r, 1'b1);
        t = (m << (FRAC + GUARD_BITS)) / r;
        for (int k = 0; k < 3; k++) begin
            if (mag[k] != 0) begin
                u = (mag[k] << FRAC) / r;
                q = (t * u) / (r << GUARD_BITS);
                if (q > 128'h8000_0000) q = 128'h8000_0000;
                case (k)
                    0: f.ax = saturate(q, d[k] >= 0);
                    1: f.ay = saturate(q, d[k] >= 0);
                    default: f.az = saturate(q, d[k] >= 0);
                endcase
            end
        end
        return f;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    function automatic logic [31:0] rand_offset();
        case ($urandom_range(3))
            0: return $urandom_range(15) - 8;
            1: return 32'($signed($urandom_range(32'h3FFFF)) - 32'sh20000);
            2: return 32'($signed($urandom_range(32'h3FF_FFFF)) - 32'sh200_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(3))
            0: return $urandom_range(32'h3_0000);
            1: return $urandom_range(32'hFF_FFFF);
            2: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                logic [31:0] mass, bit frozen, bit last);
        particle_t p;
        p.px = px; p.py = py; p.pz = pz;
        p.sx = sx; p.sy = sy; p.sz = sz;
        p.mass = mass; p.frozen = frozen; p.last = last;
        pending_particles.push_back(p);
    endtask

    task automatic add_random(int n);
        logic [31:0] sx, sy, sz;
        for (int i = 0; i < n; i++) begin
            sx = $urandom; sy = $urandom; sz = $urandom;
            if ($urandom_range(4) == 0)
                add_particle($urandom, $urandom, $urandom, sx, sy, sz, rand_mass(),
                             $urandom_range(1), $urandom_range(1));
            else
                add_particle(sx + rand_offset(), sy + rand_offset(), sz + rand_offset(),
                             sx, sy, sz, rand_mass(), $urandom_range(7) == 0,
                             $urandom_range(1));
        end
    endtask

    task automatic drain();
        wait (pending_particles.size() == 0 && !s_valid && expected_forces.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic write_core(logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        core_size_model = value;
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, want);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0; m_ready = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
        s_pos_x = '0; s_pos_y = '0; s_pos_z = '0;
        s_sat_x = '0; s_sat_y = '0; s_sat_z = '0;
        s_sat_mass = '0; s_frozen = 1'b0; s_last_in = 1'b0;
        core_size_model = 32'd32768;
        no_idle = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1);
        add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        add_particle(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0);
        add_particle(0, 32'hFFFF_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 1);
        add_particle(5, 5, 5, 5, 5, 5, 32'h0002_0000, 0, 0);
        add_particle(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
        add_particle(32'h1234_5678, 1, 2, 0, 0, 0, 32'hFFFF_FFFF, 1, 1);
        add_particle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        write_core(32'd0);
        add_particle(7, 7, 7, 7, 7, 7, 32'h0001_0000, 0, 1);
        add_particle(7, 7, 7, 7, 7, 7, 0, 0, 0);
        add_particle(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
        add_particle(0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'h0000_0100, 0, 1);
        add_particle(9, 9, 9, 9, 9, 9, 32'hFFFF_FFFF, 1, 0);
        add_random(120);
        drain();

        write_core(32'hFFFF_FFFF);
        add_particle(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1);
        add_particle(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 0, 0);
        add_random(100);
        drain();

        write_core($urandom_range(32'h3_FFFF));
        no_idle = 1'b1;
        add_random(120);
        drain();

        write_core($urandom);
        no_idle = 1'b0;
        add_random(150);
        drain();

        if (errors == 0) begin
            $display("softened_point_mass_force regression: pass");
        end else begin
            $display("softened_point_mass_force regression: fail");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                s_taken = 1'b0;
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_particles.size() > 0) begin
                    cur_particle = pending_particles.pop_front();
                    s_pos_x <= cur_particle.px; s_pos_y <= cur_particle.py;
                    s_pos_z <= cur_particle.pz; s_sat_x <= cur_particle.sx;
                    s_sat_y <= cur_particle.sy; s_sat_z <= cur_particle.sz;
                    s_sat_mass <= cur_particle.mass;
                    s_frozen <= cur_particle.frozen;
                    s_last_in <= cur_particle.last;
                    s_valid <= 1'b1;
                    s_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (m_stall > 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                m_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        force_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("softened_point_mass_force regression: fail");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_forces.push_back(plummer_force(cur_particle, core_size_model));
                s_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_forces.size() == 0) begin
                    report_mismatch("unexpected transaction", m_dpot, '0);
                end else begin
                    want = expected_forces.pop_front();
                    if (m_dacc_x !== want.ax) report_mismatch("dacc_x", m_dacc_x, want.ax);
                    if (m_dacc_y !== want.ay) report_mismatch("dacc_y", m_dacc_y, want.ay);
                    if (m_dacc_z !== want.az) report_mismatch("dacc_z", m_dacc_z, want.az);
                    if (m_dpot !== want.pot) report_mismatch("dpot", m_dpot, want.pot);
                    if (m_last_out !== want.last)
                        report_mismatch("last_out", 32'(m_last_out), 32'(want.last));
                end
            end
        end
    end

endmodule
